FILE: rtl/bws_pkg.sv
// ----------------------------------------------------------------------------
// bws_pkg: shared types and constants of the Bezier waypoint smoother
// Controller states, datapath command/status structs, the per-segment
// step table for t = j/N and the Q16 rounding helper.
// ----------------------------------------------------------------------------
package bws_pkg;

  localparam int COORD_WIDTH_DEF    = 24;
  localparam int MAX_SEG_POINTS_DEF = 32;

  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] SEG_POINTS_RST = 6'd5;

  localparam int FRAC_W    = 16;
  localparam int T_W       = FRAC_W + 1;
  localparam int REM_TBL_W = 5;
  localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SETUP,
    CS_RUN,
    CS_FINISH
  } ctl_state_t;

  // which window entries form the segment being set up
  typedef enum logic [1:0] {
    SEL_MID,
    SEL_OPEN,
    SEL_FINAL
  } seg_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     setup;
    seg_sel_t sel;
    logic     issue;
    logic     t_full;
    logic     tag_last;
    logic     tag_done;
    logic     shift_win;
    logic     clear_win;
  } dp_cmd_t;

  typedef struct packed {
    logic advance;
  } dp_stat_t;

  typedef struct packed {
    logic [T_W-1:0]       q;
    logic [REM_TBL_W-1:0] r;
  } recip_t;

  // quotient and remainder of 2^16 / n, for n = 1..32
  function automatic recip_t seg_recip(input logic [CFG_W-1:0] n);
    recip_t res;
    unique case (n)
      6'd1:    res = '{q: 17'd65536, r: 5'd0};
      6'd2:    res = '{q: 17'd32768, r: 5'd0};
      6'd3:    res = '{q: 17'd21845, r: 5'd1};
      6'd4:    res = '{q: 17'd16384, r: 5'd0};
      6'd5:    res = '{q: 17'd13107, r: 5'd1};
      6'd6:    res = '{q: 17'd10922, r: 5'd4};
      6'd7:    res = '{q: 17'd9362,  r: 5'd2};
      6'd8:    res = '{q: 17'd8192,  r: 5'd0};
      6'd9:    res = '{q: 17'd7281,  r: 5'd7};
      6'd10:   res = '{q: 17'd6553,  r: 5'd6};
      6'd11:   res = '{q: 17'd5957,  r: 5'd9};
      6'd12:   res = '{q: 17'd5461,  r: 5'd4};
      6'd13:   res = '{q: 17'd5041,  r: 5'd3};
      6'd14:   res = '{q: 17'd4681,  r: 5'd2};
      6'd15:   res = '{q: 17'd4369,  r: 5'd1};
      6'd16:   res = '{q: 17'd4096,  r: 5'd0};
      6'd17:   res = '{q: 17'd3855,  r: 5'd1};
      6'd18:   res = '{q: 17'd3640,  r: 5'd16};
      6'd19:   res = '{q: 17'd3449,  r: 5'd5};
      6'd20:   res = '{q: 17'd3276,  r: 5'd16};
      6'd21:   res = '{q: 17'd3120,  r: 5'd16};
      6'd22:   res = '{q: 17'd2978,  r: 5'd20};
      6'd23:   res = '{q: 17'd2849,  r: 5'd9};
      6'd24:   res = '{q: 17'd2730,  r: 5'd16};
      6'd25:   res = '{q: 17'd2621,  r: 5'd11};
      6'd26:   res = '{q: 17'd2520,  r: 5'd16};
      6'd27:   res = '{q: 17'd2427,  r: 5'd7};
      6'd28:   res = '{q: 17'd2340,  r: 5'd16};
      6'd29:   res = '{q: 17'd2259,  r: 5'd25};
      6'd30:   res = '{q: 17'd2184,  r: 5'd16};
      6'd31:   res = '{q: 17'd2114,  r: 5'd2};
      6'd32:   res = '{q: 17'd2048,  r: 5'd0};
      default: res = '{q: T_ONE,     r: 5'd0};
    endcase
    return res;
  endfunction

  // (v + 2^15) >> 16 on a product of two Q1.16 values
  function automatic logic [T_W-1:0] rnd_q16(input logic [2*T_W+1:0] v);
    logic [2*T_W+1:0] s;
    s = v + ((2*T_W+2)'(1) << (FRAC_W - 1));
    return s[FRAC_W+T_W-1:FRAC_W];
  endfunction

endpackage

FILE: rtl/bws_way_if.sv
// ----------------------------------------------------------------------------
// bws_way_if: waypoint input channel
// Valid/ready channel carrying one waypoint and its end-of-path flag.
// ----------------------------------------------------------------------------
interface bws_way_if
  import bws_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] way_x;
  logic signed [COORD_WIDTH-1:0] way_y;
  logic                          path_end;

  modport source (output valid, way_x, way_y, path_end, input ready);
  modport sink   (input valid, way_x, way_y, path_end, output ready);
endinterface

FILE: rtl/bws_pt_if.sv
// ----------------------------------------------------------------------------
// bws_pt_if: smoothed point output channel
// Valid/ready channel carrying one path point and its framing flags.
// ----------------------------------------------------------------------------
interface bws_pt_if
  import bws_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pt_x;
  logic signed [COORD_WIDTH-1:0] pt_y;
  logic                          run_last;
  logic                          path_done;

  modport source (output valid, pt_x, pt_y, run_last, path_done, input ready);
  modport sink   (input valid, pt_x, pt_y, run_last, path_done, output ready);
endinterface

FILE: rtl/bws_datapath.sv
// ----------------------------------------------------------------------------
// bws_datapath: window, control points and Bezier evaluation pipeline
// Holds the waypoint window, builds the segment control points, steps t and
// runs each point through a five-stage weight/product/sum pipeline.
// ----------------------------------------------------------------------------
module bws_datapath
  import bws_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int MAX_SEG_POINTS = MAX_SEG_POINTS_DEF,
  localparam int CNT_W         = $clog2(MAX_SEG_POINTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat,
  input  logic [CNT_W-1:0]              seg_n,
  input  logic signed [COORD_WIDTH-1:0] way_x,
  input  logic signed [COORD_WIDTH-1:0] way_y,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] pt_x,
  output logic signed [COORD_WIDTH-1:0] pt_y,
  output logic                          run_last,
  output logic                          path_done
);

  localparam int CW  = COORD_WIDTH;
  localparam int PW  = CW + 1;
  localparam int DW  = CW + 2;
  localparam int PRW = PW + T_W + 1;
  localparam int SW  = PRW + 2;
  localparam int NAX = 2;
  localparam int NCP = 4;
  localparam int NWIN = 3;
  localparam int NST = 5;

  localparam logic signed [SW-1:0] RND_HALF  = SW'(1) <<< (FRAC_W - 1);
  localparam logic signed [SW-1:0] COORD_MAX = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] COORD_MIN = -COORD_MAX - SW'(1);

  logic                   advance;
  logic signed [CW-1:0]   in_p  [NAX];
  logic signed [CW-1:0]   win   [NAX][NWIN];
  logic signed [CW-1:0]   sel_l [NAX];
  logic signed [CW-1:0]   sel_a [NAX];
  logic signed [CW-1:0]   sel_b [NAX];
  logic signed [CW-1:0]   sel_r [NAX];
  logic signed [DW-1:0]   dl    [NAX];
  logic signed [DW-1:0]   dr    [NAX];
  logic signed [DW-1:0]   p1_w  [NAX];
  logic signed [DW-1:0]   p2_w  [NAX];
  logic signed [PW-1:0]   seg_p [NAX][NCP];

  logic [T_W-1:0]         tacc;
  logic [CNT_W-1:0]       rem;
  recip_t                 recip;
  logic [CNT_W:0]         rem_sum;
  logic [CNT_W:0]         rem_new;
  logic                   rem_carry;
  logic [T_W-1:0]         t_new;
  logic                   issue_fire;

  logic [NST-1:0]         vld;
  logic [NST-1:0]         tag_last;
  logic [NST-1:0]         tag_done;
  logic [T_W-1:0]         t0;
  logic [T_W-1:0]         u0;
  logic [T_W-1:0]         t1;
  logic [T_W-1:0]         u1;
  logic [T_W-1:0]         tt1;
  logic [T_W-1:0]         uu1;
  logic [T_W-1:0]         wt2   [NCP];
  logic signed [PW-1:0]   c0    [NAX][NCP];
  logic signed [PW-1:0]   c1    [NAX][NCP];
  logic signed [PW-1:0]   c2    [NAX][NCP];
  logic [2*T_W-1:0]       m_tt;
  logic [2*T_W-1:0]       m_uu;
  logic [2*T_W-1:0]       m_ttt;
  logic [2*T_W-1:0]       m_uuu;
  logic [2*T_W-1:0]       m_w1;
  logic [2*T_W-1:0]       m_w2;
  logic signed [PRW-1:0]  prod3 [NAX][NCP];
  logic signed [SW-1:0]   sum4  [NAX];
  logic signed [SW-1:0]   shifted [NAX];
  logic signed [CW-1:0]   sat_v [NAX];

  // whole pipeline moves when the output register is free or being drained
  assign advance      = !out_valid || out_ready;
  assign stat.advance = advance;
  assign issue_fire   = cmd.issue && advance;

  // input latch and waypoint window
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_p[0] <= way_x;
      in_p[1] <= way_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ax = 0; ax < NAX; ax++) begin
        for (int i = 0; i < NWIN; i++) begin
          win[ax][i] <= '0;
        end
      end
    end else if (cmd.clear_win) begin
      for (int ax = 0; ax < NAX; ax++) begin
        for (int i = 0; i < NWIN; i++) begin
          win[ax][i] <= '0;
        end
      end
    end else if (cmd.shift_win) begin
      for (int ax = 0; ax < NAX; ax++) begin
        win[ax][0] <= win[ax][1];
        win[ax][1] <= win[ax][2];
        win[ax][2] <= in_p[ax];
      end
    end
  end

  // segment selection and quarter-tangent control points
  always_comb begin
    for (int ax = 0; ax < NAX; ax++) begin
      unique case (cmd.sel)
        SEL_MID: begin
          sel_l[ax] = win[ax][0];
          sel_a[ax] = win[ax][1];
          sel_b[ax] = win[ax][2];
          sel_r[ax] = in_p[ax];
        end
        SEL_OPEN: begin
          sel_l[ax] = win[ax][1];
          sel_a[ax] = win[ax][1];
          sel_b[ax] = win[ax][2];
          sel_r[ax] = in_p[ax];
        end
        default: begin
          sel_l[ax] = win[ax][1];
          sel_a[ax] = win[ax][2];
          sel_b[ax] = in_p[ax];
          sel_r[ax] = in_p[ax];
        end
      endcase
      dl[ax]   = DW'(sel_b[ax]) - DW'(sel_l[ax]) + DW'(2);
      dr[ax]   = DW'(sel_r[ax]) - DW'(sel_a[ax]) + DW'(2);
      p1_w[ax] = DW'(sel_a[ax]) + (dl[ax] >>> 2);
      p2_w[ax] = DW'(sel_b[ax]) - (dr[ax] >>> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      for (int ax = 0; ax < NAX; ax++) begin
        seg_p[ax][0] <= PW'(sel_a[ax]);
        seg_p[ax][1] <= p1_w[ax][PW-1:0];
        seg_p[ax][2] <= p2_w[ax][PW-1:0];
        seg_p[ax][3] <= PW'(sel_b[ax]);
      end
    end
  end

  // t = floor(j * 2^16 / N), stepped by quotient plus remainder carry
  assign recip     = seg_recip(CFG_W'(seg_n));
  assign rem_sum   = {1'b0, rem} + (CNT_W+1)'(recip.r);
  assign rem_carry = rem_sum >= {1'b0, seg_n};
  assign rem_new   = rem_carry ? rem_sum - {1'b0, seg_n} : rem_sum;
  assign t_new     = tacc + recip.q + T_W'(rem_carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      tacc <= '0;
      rem  <= '0;
    end else if (cmd.setup) begin
      tacc <= '0;
      rem  <= '0;
    end else if (issue_fire) begin
      tacc <= t_new;
      rem  <= rem_new[CNT_W-1:0];
    end
  end

  // weight products
  assign u0    = T_ONE - t0;
  assign m_tt  = t0 * t0;
  assign m_uu  = u0 * u0;
  assign m_ttt = tt1 * t1;
  assign m_uuu = uu1 * u1;
  assign m_w1  = uu1 * t1;
  assign m_w2  = u1 * tt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      tag_last <= '0;
      tag_done <= '0;
    end else if (advance) begin
      vld      <= {vld[NST-2:0], issue_fire};
      tag_last <= {tag_last[NST-2:0], cmd.tag_last};
      tag_done <= {tag_done[NST-2:0], cmd.tag_done};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // stage 0: t and a private copy of the segment
      t0  <= cmd.t_full ? T_ONE : t_new;
      c0  <= seg_p;
      // stage 1: squares
      t1  <= t0;
      u1  <= u0;
      tt1 <= rnd_q16((2*T_W+2)'(m_tt));
      uu1 <= rnd_q16((2*T_W+2)'(m_uu));
      c1  <= c0;
      // stage 2: Bernstein weights
      wt2[0] <= rnd_q16((2*T_W+2)'(m_uuu));
      wt2[1] <= rnd_q16(((2*T_W+2)'(m_w1) << 1) + (2*T_W+2)'(m_w1));
      wt2[2] <= rnd_q16(((2*T_W+2)'(m_w2) << 1) + (2*T_W+2)'(m_w2));
      wt2[3] <= rnd_q16((2*T_W+2)'(m_ttt));
      c2     <= c1;
      // stage 3: weight times control point
      for (int ax = 0; ax < NAX; ax++) begin
        for (int k = 0; k < NCP; k++) begin
          prod3[ax][k] <= $signed({1'b0, wt2[k]}) * c2[ax][k];
        end
      end
      // stage 4: sum with rounding offset
      for (int ax = 0; ax < NAX; ax++) begin
        sum4[ax] <= SW'(prod3[ax][0]) + SW'(prod3[ax][1]) + SW'(prod3[ax][2])
                    + SW'(prod3[ax][3]) + RND_HALF;
      end
    end
  end

  // scale back and saturate
  always_comb begin
    for (int ax = 0; ax < NAX; ax++) begin
      shifted[ax] = sum4[ax] >>> FRAC_W;
      if (shifted[ax] > COORD_MAX) begin
        sat_v[ax] = COORD_MAX[CW-1:0];
      end else if (shifted[ax] < COORD_MIN) begin
        sat_v[ax] = COORD_MIN[CW-1:0];
      end else begin
        sat_v[ax] = shifted[ax][CW-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pt_x      <= sat_v[0];
      pt_y      <= sat_v[1];
      run_last  <= tag_last[NST-1];
      path_done <= tag_done[NST-1];
    end
  end

endmodule

FILE: rtl/bws_ctrl.sv
// ----------------------------------------------------------------------------
// bws_ctrl: sequencing of one waypoint transaction
// Decides echo, silent fill or segment work from the fill level, issues
// one point per cycle to the datapath unless stalled, then retires the window.
// ----------------------------------------------------------------------------
module bws_ctrl
  import bws_pkg::*;
#(
  parameter int MAX_SEG_POINTS = MAX_SEG_POINTS_DEF,
  localparam int CNT_W         = $clog2(MAX_SEG_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             path_end,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd,
  output logic [CNT_W-1:0] seg_n
);

  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_FULL = 2'd3;

  ctl_state_t       state;
  ctl_state_t       state_next;
  logic [CFG_W-1:0] seg_points;
  logic [1:0]       seen;
  logic             end_flag;
  logic             echo;
  logic             final_pend;
  seg_sel_t         sel;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] limit_m1;
  logic             last_pt;
  logic             is_echo;

  always_comb begin
    priority if (seg_points == '0) begin
      seg_n = CNT_W'(1);
    end else if (seg_points > CFG_W'(MAX_SEG_POINTS)) begin
      seg_n = CNT_W'(MAX_SEG_POINTS);
    end else begin
      seg_n = CNT_W'(seg_points);
    end
  end

  assign limit    = echo ? CNT_W'(1) : seg_n;
  assign limit_m1 = limit - CNT_W'(1);
  assign last_pt  = (j == limit_m1);
  assign is_echo  = (seen == '0) || (seen == SEEN_ONE && path_end);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (in_valid) begin
          if (seen == SEEN_ONE && !path_end) begin
            state_next = CS_FINISH;
          end else begin
            state_next = CS_SETUP;
          end
        end
      end
      CS_SETUP: state_next = CS_RUN;
      CS_RUN: begin
        if (stat.advance && last_pt) begin
          state_next = final_pend ? CS_SETUP : CS_FINISH;
        end
      end
      CS_FINISH: state_next = CS_IDLE;
      default:   state_next = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.sel  = sel;
    in_ready = 1'b0;
    unique case (state)
      CS_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      CS_SETUP: cmd.setup = 1'b1;
      CS_RUN: begin
        cmd.issue    = 1'b1;
        cmd.t_full   = echo;
        cmd.tag_last = last_pt && !final_pend;
        cmd.tag_done = last_pt && !final_pend && end_flag;
      end
      CS_FINISH: begin
        cmd.shift_win = !end_flag;
        cmd.clear_win = end_flag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CS_IDLE;
      seg_points <= SEG_POINTS_RST;
      seen       <= '0;
      end_flag   <= 1'b0;
      echo       <= 1'b0;
      final_pend <= 1'b0;
      sel        <= SEL_MID;
      j          <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        seg_points <= cfg_wdata;
      end
      if (state == CS_IDLE && in_valid) begin
        end_flag <= path_end;
        if (is_echo) begin
          echo       <= 1'b1;
          sel        <= SEL_FINAL;
          final_pend <= 1'b0;
        end else begin
          echo       <= 1'b0;
          sel        <= (seen == SEEN_TWO) ? SEL_OPEN : SEL_MID;
          final_pend <= path_end;
        end
      end
      if (state == CS_SETUP) begin
        j <= '0;
      end
      if (state == CS_RUN && stat.advance) begin
        j <= j + CNT_W'(1);
        if (last_pt && final_pend) begin
          final_pend <= 1'b0;
          sel        <= SEL_FINAL;
        end
      end
      if (state == CS_FINISH) begin
        if (end_flag) begin
          seen <= '0;
        end else if (seen != SEEN_FULL) begin
          seen <= seen + 2'd1;
        end
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != CS_IDLE))
    else $error("accepted transaction did not start work");

  a_point_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == CS_RUN) |-> (j <= limit_m1))
    else $error("point counter ran past the segment length");

  a_seen_only_in_finish: assert property (@(posedge clk) disable iff (rst)
    (state != CS_FINISH) |=> $stable(seen))
    else $error("fill level changed outside retirement");

  a_echo_single_segment: assert property (@(posedge clk) disable iff (rst)
    final_pend |-> !echo)
    else $error("echo transaction has a pending final segment");

endmodule

FILE: rtl/bezier_waypoint_smoother_core.sv
// ----------------------------------------------------------------------------
// Throughput: one point per cycle from the single evaluation pipeline while
// the output side does not stall; a waypoint yields N points, 2N when it
// closes a path with two segments, one for an echoed point and none for a
// silent one.
// Reset: synchronous; controller idle, window and fill level cleared,
// segment_points = 5, output empty; no clearing pass.
// ----------------------------------------------------------------------------
// bezier_waypoint_smoother_core: streaming cubic Bezier path smoother
// Takes waypoints one transaction at a time and emits N Bezier points per
// segment, with quarter-tangent control points and one-sided ends.
// ----------------------------------------------------------------------------
module bezier_waypoint_smoother_core
  import bws_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int MAX_SEG_POINTS = MAX_SEG_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  bws_way_if.sink          way,
  bws_pt_if.source         pt,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_SEG_POINTS + 1);

  // command and status between the sequencer and the datapath
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  // clamped points per segment, shared by the counter and the t stepper
  logic [CNT_W-1:0] seg_n;

  // Sequencer: takes the waypoint transaction, chooses echo, silent fill or
  // segment work from the fill level and path_end, then walks j = 1..N one
  // point per cycle, holding whenever the output side stalls.
  bws_ctrl #(
    .MAX_SEG_POINTS (MAX_SEG_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (way.valid),
    .in_ready  (way.ready),
    .path_end  (way.path_end),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd),
    .seg_n     (seg_n)
  );

  // Datapath: window of the last three waypoints, control point setup and
  // the weight/product/sum pipeline that ends in the output register. Each
  // point carries its own copy of the segment, so the next setup may start
  // while earlier points still drain.
  bws_datapath #(
    .COORD_WIDTH    (COORD_WIDTH),
    .MAX_SEG_POINTS (MAX_SEG_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .seg_n     (seg_n),
    .way_x     (way.way_x),
    .way_y     (way.way_y),
    .out_ready (pt.ready),
    .out_valid (pt.valid),
    .pt_x      (pt.pt_x),
    .pt_y      (pt.pt_y),
    .run_last  (pt.run_last),
    .path_done (pt.path_done)
  );

endmodule
